// File: design/assert_macros.svh
// Assertion macros used by the port checker of the step scheduler.
// Guarded against double inclusion; holds macro definitions only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a clock, switched off while reset is low
`define CHSS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("step scheduler port check failed");

// Concurrent assertion on a clock that also holds through reset
`define CHSS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("step scheduler port check failed");

`endif

// File: design/chss_pkg.sv
// Shared types and constants of the clock hand step scheduler.
// No dependencies; imported by every module of the block.
package chss_pkg;

  // Field widths of the item and result words
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned NOW_W     = 32;
  localparam int unsigned TGT_W     = 16;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned WAIT_W    = 16;
  localparam int unsigned OUT_POS_W = 16;

  // Configuration register widths and reset values
  localparam int unsigned GAP_W  = 20;
  localparam int unsigned TURN_W = 16;
  localparam logic [GAP_W-1:0]  GAP_RESET  = 20'd1000;
  localparam logic [TURN_W-1:0] TURN_RESET = 16'd4320;

  // Step delay unit in microseconds, and a width that holds gap + 100 * delay
  localparam int unsigned STEP_UNIT_US = 100;
  localparam int unsigned LIMIT_W      = 21;

  // Register port
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned REG_SEL_BIT = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_STEP = 2'd0,
    CMD_ZERO = 2'd1,
    CMD_LOAD = 2'd2
  } cmd_e;

  typedef enum logic {
    REG_MIN_GAP   = 1'b0,
    REG_FULL_TURN = 1'b1
  } reg_e;

  typedef struct packed {
    logic [GAP_W-1:0]  min_gap;
    logic [TURN_W-1:0] full_turn;
  } cfg_t;

endpackage

// File: design/chss_hand.sv
// Step decision and next state of one stepper hand for a try-step word.
// Depends on chss_pkg.
module chss_hand #(
  parameter int unsigned POS_BITS = 16
) (
  input  chss_pkg::cfg_t                   cfg_i,
  input  logic [chss_pkg::NOW_W-1:0]       now_i,
  input  logic [chss_pkg::TGT_W-1:0]       target_i,
  input  logic                             forward_i,
  input  logic [chss_pkg::DELAY_W-1:0]     delay_i,
  input  logic [POS_BITS-1:0]              pos_i,
  input  logic [chss_pkg::NOW_W-1:0]       last_i,
  input  logic [chss_pkg::WAIT_W-1:0]      wait_i,
  output logic [POS_BITS-1:0]              pos_o,
  output logic [chss_pkg::NOW_W-1:0]       last_o,
  output logic [chss_pkg::WAIT_W-1:0]      wait_o,
  output logic                             moved_o
);
  import chss_pkg::*;

  localparam int unsigned CMP_W = (POS_BITS > TGT_W) ? POS_BITS : TGT_W;
  localparam int unsigned INC_W = (POS_BITS + 1 > TURN_W) ? POS_BITS + 1 : TURN_W;

  logic [NOW_W-1:0]    diff;
  logic [LIMIT_W-1:0]  delay_us;
  logic [LIMIT_W-1:0]  limit;
  logic                off_target;
  logic                due;
  logic [INC_W-1:0]    pos_inc;
  logic [POS_BITS-1:0] pos_fwd;
  logic [POS_BITS-1:0] pos_bwd;

  // Time since the last step, and the gap this hand must leave
  assign diff     = now_i - last_i;
  assign delay_us = LIMIT_W'(delay_i) * LIMIT_W'(STEP_UNIT_US);
  assign limit    = LIMIT_W'(cfg_i.min_gap) + delay_us;
  // A negative difference means the time wrapped: act at once
  assign due      = diff[NOW_W-1] || (diff > NOW_W'(limit));

  assign off_target = CMP_W'(pos_i) != CMP_W'(target_i);

  // Wrap forward past the full turn to zero, backward from zero to the full turn
  assign pos_inc = INC_W'(pos_i) + INC_W'(1);
  assign pos_fwd = (pos_inc > INC_W'(cfg_i.full_turn)) ? '0 : pos_inc[POS_BITS-1:0];
  assign pos_bwd = (pos_i == '0) ? POS_BITS'(cfg_i.full_turn) : pos_i - POS_BITS'(1);

  // Spend a wait step first, otherwise move
  always_comb begin
    pos_o   = pos_i;
    last_o  = last_i;
    wait_o  = wait_i;
    moved_o = 1'b0;
    if (off_target && due) begin
      last_o = now_i;
      if (wait_i != '0) begin
        wait_o = wait_i - WAIT_W'(1);
      end else begin
        moved_o = 1'b1;
        pos_o   = forward_i ? pos_fwd : pos_bwd;
      end
    end
  end

endmodule

// File: design/chss_state_ram.sv
// Per-clock state store: one write port, one registered read port with a
// write-to-read bypass for back-to-back words. Depends on chss_pkg.
module chss_state_ram #(
  parameter  int unsigned DEPTH  = 24,
  parameter  int unsigned WIDTH  = 128,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);
  import chss_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write the store
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read, taking the word written at the same edge to the same entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/clock_hand_step_scheduler_unit.sv
// Top level of the clock hand step scheduler: register port, input stage,
// state store and result register. Depends on chss_pkg, chss_hand, chss_state_ram.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------
//   in       | in_valid_i / in_ready_o | cmd, clock address, time, hand controls
//   out      | out_valid_o/out_ready_i | positions, moved flags, on_target
//   register | psel/penable/pready     | paddr, pwdata, prdata (32 bits)
//
// One word per cycle while no held result stalls the second stage. The accepting edge
// loads the input register and the state store read (registered, with bypass); the hand
// update is registered into the result register when the second stage advances.
// After reset a clearing pass zeroes the GRID_COLS * GRID_ROWS store entries in turn;
// in_ready_o stays low through it, register writes are taken as ever.
// A held result stalls the second stage; in_ready_o drops while that stage is stalled.
module clock_hand_step_scheduler_unit #(
  parameter int unsigned GRID_COLS = 8,
  parameter int unsigned GRID_ROWS = 3,
  parameter int unsigned POS_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [chss_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [chss_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [chss_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // input words
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [chss_pkg::CMD_W-1:0]          cmd_i,
  input  logic [chss_pkg::COL_W-1:0]          clock_col_i,
  input  logic [chss_pkg::ROW_W-1:0]          clock_row_i,
  input  logic [chss_pkg::NOW_W-1:0]          now_us_i,
  input  logic [chss_pkg::TGT_W-1:0]          hour_target_i,
  input  logic [chss_pkg::TGT_W-1:0]          minute_target_i,
  input  logic                                hour_forward_i,
  input  logic                                minute_forward_i,
  input  logic [chss_pkg::DELAY_W-1:0]        hour_delay_i,
  input  logic [chss_pkg::DELAY_W-1:0]        minute_delay_i,
  input  logic [chss_pkg::WAIT_W-1:0]         hour_wait_load_i,
  input  logic [chss_pkg::WAIT_W-1:0]         minute_wait_load_i,
  // result words
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [chss_pkg::OUT_POS_W-1:0]      hour_position_o,
  output logic [chss_pkg::OUT_POS_W-1:0]      minute_position_o,
  output logic                                hour_moved_o,
  output logic                                minute_moved_o,
  output logic                                on_target_o
);
  import chss_pkg::*;

  localparam int unsigned CLOCK_COUNT = GRID_COLS * GRID_ROWS;
  localparam int unsigned IDX_W       = (CLOCK_COUNT > 1) ? $clog2(CLOCK_COUNT) : 1;
  localparam int unsigned CMP_W       = (POS_BITS > TGT_W) ? POS_BITS : TGT_W;

  typedef struct packed {
    logic [POS_BITS-1:0] hour_pos;
    logic [POS_BITS-1:0] min_pos;
    logic [NOW_W-1:0]    hour_last;
    logic [NOW_W-1:0]    min_last;
    logic [WAIT_W-1:0]   hour_wait;
    logic [WAIT_W-1:0]   min_wait;
  } word_t;

  localparam int unsigned WORD_W = $bits(word_t);

  typedef struct packed {
    cmd_e               cmd;
    logic               in_grid;
    logic [IDX_W-1:0]   idx;
    logic [NOW_W-1:0]   now;
    logic [TGT_W-1:0]   hour_tgt;
    logic [TGT_W-1:0]   min_tgt;
    logic               hour_fwd;
    logic               min_fwd;
    logic [DELAY_W-1:0] hour_dly;
    logic [DELAY_W-1:0] min_dly;
    logic [WAIT_W-1:0]  hour_ld;
    logic [WAIT_W-1:0]  min_ld;
  } item_t;

  // ---------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------
  cfg_t cfg_q;
  logic reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_gap   <= GAP_RESET;
      cfg_q.full_turn <= TURN_RESET;
    end else if (reg_write) begin
      unique case (reg_e'(paddr[REG_SEL_BIT]))
        REG_MIN_GAP:   cfg_q.min_gap   <= pwdata[GAP_W-1:0];
        REG_FULL_TURN: cfg_q.full_turn <= pwdata[TURN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[REG_SEL_BIT]))
      REG_MIN_GAP:   prdata = APB_DATA_W'(cfg_q.min_gap);
      REG_FULL_TURN: prdata = APB_DATA_W'(cfg_q.full_turn);
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Clearing pass after reset
  // ---------------------------------------------------------------------
  logic             clr_active_q, clr_active_d;
  logic [IDX_W-1:0] clr_idx_q, clr_idx_d;

  always_comb begin
    clr_active_d = clr_active_q;
    clr_idx_d    = clr_idx_q;
    if (clr_active_q) begin
      if (clr_idx_q == IDX_W'(CLOCK_COUNT - 1)) begin
        clr_active_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_idx_q    <= '0;
    end else begin
      clr_active_q <= clr_active_d;
      clr_idx_q    <= clr_idx_d;
    end
  end

  // ---------------------------------------------------------------------
  // Input stage: capture the word and start the state read
  // ---------------------------------------------------------------------
  item_t            s1_q;
  logic             s1_valid_q;
  logic             s1_adv;
  logic             in_fire;
  logic             in_grid;
  logic [31:0]      idx_full;
  logic [IDX_W-1:0] rd_idx;
  logic             out_valid_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_active_q && (!s1_valid_q || s1_adv);
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_grid  = (32'(clock_col_i) < GRID_COLS) && (32'(clock_row_i) < GRID_ROWS);
  assign idx_full = 32'(clock_col_i) * GRID_ROWS + 32'(clock_row_i);
  assign rd_idx   = in_grid ? idx_full[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.cmd      <= cmd_e'(cmd_i);
      s1_q.in_grid  <= in_grid;
      s1_q.idx      <= rd_idx;
      s1_q.now      <= now_us_i;
      s1_q.hour_tgt <= hour_target_i;
      s1_q.min_tgt  <= minute_target_i;
      s1_q.hour_fwd <= hour_forward_i;
      s1_q.min_fwd  <= minute_forward_i;
      s1_q.hour_dly <= hour_delay_i;
      s1_q.min_dly  <= minute_delay_i;
      s1_q.hour_ld  <= hour_wait_load_i;
      s1_q.min_ld   <= minute_wait_load_i;
    end
  end

  // ---------------------------------------------------------------------
  // State store
  // ---------------------------------------------------------------------
  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [WORD_W-1:0] st_wdata;
  logic [WORD_W-1:0] st_rdata;
  word_t             rd;
  word_t             wr;

  assign st_we    = clr_active_q || (s1_adv && s1_q.in_grid);
  assign st_waddr = clr_active_q ? clr_idx_q : s1_q.idx;
  assign st_wdata = clr_active_q ? '0 : WORD_W'(wr);
  assign rd       = word_t'(st_rdata);

  chss_state_ram #(
    .DEPTH (CLOCK_COUNT),
    .WIDTH (WORD_W)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (in_fire),
    .raddr_i (rd_idx),
    .rdata_o (st_rdata)
  );

  // ---------------------------------------------------------------------
  // Hand updates
  // ---------------------------------------------------------------------
  logic [POS_BITS-1:0] h_pos, m_pos;
  logic [NOW_W-1:0]    h_last, m_last;
  logic [WAIT_W-1:0]   h_wait, m_wait;
  logic                h_moved, m_moved;

  chss_hand #(.POS_BITS(POS_BITS)) u_hour_hand (
    .cfg_i     (cfg_q),
    .now_i     (s1_q.now),
    .target_i  (s1_q.hour_tgt),
    .forward_i (s1_q.hour_fwd),
    .delay_i   (s1_q.hour_dly),
    .pos_i     (rd.hour_pos),
    .last_i    (rd.hour_last),
    .wait_i    (rd.hour_wait),
    .pos_o     (h_pos),
    .last_o    (h_last),
    .wait_o    (h_wait),
    .moved_o   (h_moved)
  );

  chss_hand #(.POS_BITS(POS_BITS)) u_minute_hand (
    .cfg_i     (cfg_q),
    .now_i     (s1_q.now),
    .target_i  (s1_q.min_tgt),
    .forward_i (s1_q.min_fwd),
    .delay_i   (s1_q.min_dly),
    .pos_i     (rd.min_pos),
    .last_i    (rd.min_last),
    .wait_i    (rd.min_wait),
    .pos_o     (m_pos),
    .last_o    (m_last),
    .wait_o    (m_wait),
    .moved_o   (m_moved)
  );

  // Pick the new state of the addressed clock by command
  logic hm, mm;

  always_comb begin
    wr = rd;
    hm = 1'b0;
    mm = 1'b0;
    unique case (s1_q.cmd)
      CMD_STEP: begin
        wr.hour_pos  = h_pos;
        wr.hour_last = h_last;
        wr.hour_wait = h_wait;
        wr.min_pos   = m_pos;
        wr.min_last  = m_last;
        wr.min_wait  = m_wait;
        hm           = h_moved;
        mm           = m_moved;
      end
      CMD_ZERO: begin
        wr.hour_pos = '0;
        wr.min_pos  = '0;
      end
      CMD_LOAD: begin
        wr.hour_wait = s1_q.hour_ld;
        wr.min_wait  = s1_q.min_ld;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic hit_h, hit_m;

  assign hit_h = CMP_W'(wr.hour_pos) == CMP_W'(s1_q.hour_tgt);
  assign hit_m = CMP_W'(wr.min_pos) == CMP_W'(s1_q.min_tgt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Out-of-grid words report all zero
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      hour_position_o   <= s1_q.in_grid ? OUT_POS_W'(wr.hour_pos) : '0;
      minute_position_o <= s1_q.in_grid ? OUT_POS_W'(wr.min_pos) : '0;
      hour_moved_o      <= s1_q.in_grid && hm;
      minute_moved_o    <= s1_q.in_grid && mm;
      on_target_o       <= s1_q.in_grid && hit_h && hit_m;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: design/chss_port_checker.sv
// Port-level checks of the step scheduler, bound to the top level.
// Depends on assert_macros.svh and clock_hand_step_scheduler_unit.
`include "assert_macros.svh"

module chss_port_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [chss_pkg::OUT_POS_W-1:0]    hour_position_o,
  input logic [chss_pkg::OUT_POS_W-1:0]    minute_position_o,
  input logic                              hour_moved_o,
  input logic                              minute_moved_o,
  input logic                              on_target_o
);
  import chss_pkg::*;

  // A held result keeps its word
  `CHSS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(hour_position_o) && $stable(minute_position_o) && $stable(hour_moved_o) && $stable(minute_moved_o) && $stable(on_target_o))

  // A result appearing from empty came from an accepted input word
  `CHSS_ASSERT(a_out_latency, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))

  // The clearing pass keeps the input closed after reset
  `CHSS_ASSERT_ALWAYS(a_clear_closed, clk_i, !rst_ni |=> !in_ready_o)

  // With the result side empty and staying empty, an open input stays open
  `CHSS_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o && $past(!out_valid_o) && $past(in_ready_o) |-> in_ready_o)

endmodule

bind clock_hand_step_scheduler_unit chss_port_checker u_chss_port_checker (.*);

// File: tb/chss_step_checker.sv
// Checker for the clock hand step scheduler: follows register writes, predicts
// one result word per accepted input word and compares the result channel.
// Depends on chss_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 100ps

module chss_step_checker
  import chss_pkg::*;
#(
  parameter int unsigned GRID_COLS = 8,
  parameter int unsigned GRID_ROWS = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  // input words
  input  logic                  in_valid_i,
  input  logic                  in_ready_o,
  input  logic [CMD_W-1:0]      cmd_i,
  input  logic [COL_W-1:0]      clock_col_i,
  input  logic [ROW_W-1:0]      clock_row_i,
  input  logic [NOW_W-1:0]      now_us_i,
  input  logic [TGT_W-1:0]      hour_target_i,
  input  logic [TGT_W-1:0]      minute_target_i,
  input  logic                  hour_forward_i,
  input  logic                  minute_forward_i,
  input  logic [DELAY_W-1:0]    hour_delay_i,
  input  logic [DELAY_W-1:0]    minute_delay_i,
  input  logic [WAIT_W-1:0]     hour_wait_load_i,
  input  logic [WAIT_W-1:0]     minute_wait_load_i,
  // result words
  input  logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  logic [OUT_POS_W-1:0]  hour_position_o,
  input  logic [OUT_POS_W-1:0]  minute_position_o,
  input  logic                  hour_moved_o,
  input  logic                  minute_moved_o,
  input  logic                  on_target_o,
  // totals for the top
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen,
  output int                    moves_seen
);

  localparam int unsigned CLOCKS = GRID_COLS * GRID_ROWS;

  typedef struct packed {
    logic [OUT_POS_W-1:0] hour_pos;
    logic [OUT_POS_W-1:0] minute_pos;
    logic                 hour_moved;
    logic                 minute_moved;
    logic                 on_target;
  } result_t;

  typedef struct packed {
    logic [OUT_POS_W-1:0] pos;
    logic [NOW_W-1:0]     last;
    logic [WAIT_W-1:0]    wait_cnt;
    logic                 moved;
  } hand_t;

  // Per-clock copy of the hand state
  logic [OUT_POS_W-1:0] hour_pos_tab    [CLOCKS];
  logic [OUT_POS_W-1:0] minute_pos_tab  [CLOCKS];
  logic [NOW_W-1:0]     hour_last_tab   [CLOCKS];
  logic [NOW_W-1:0]     minute_last_tab [CLOCKS];
  logic [WAIT_W-1:0]    hour_wait_tab   [CLOCKS];
  logic [WAIT_W-1:0]    minute_wait_tab [CLOCKS];

  logic [GAP_W-1:0]  gap_cfg;
  logic [TURN_W-1:0] turn_cfg;

  result_t due_words[$];
  result_t got;
  result_t want;
  hand_t   hour_h;
  hand_t   minute_h;
  int      slot;
  int      reports;

  // One hand: check the step time, then use up a wait step or move one step
  function automatic hand_t hand_advance(hand_t h, logic [TGT_W-1:0] target,
                                         logic [NOW_W-1:0] now, logic fwd,
                                         logic [DELAY_W-1:0] delay,
                                         logic [GAP_W-1:0] gap,
                                         logic [TURN_W-1:0] turn);
    hand_t             n;
    logic [NOW_W-1:0]  diff;
    logic [31:0]       limit;
    logic [OUT_POS_W:0] up;
    n = h;
    n.moved = 1'b0;
    if (h.pos == target) return n;
    diff  = now - h.last;
    limit = 32'(gap) + 32'(delay) * STEP_UNIT_US;
    // a negative difference always acts
    if (!diff[NOW_W-1] && diff <= limit) return n;
    n.last = now;
    if (h.wait_cnt != '0) begin
      n.wait_cnt = h.wait_cnt - 1'b1;
      return n;
    end
    n.moved = 1'b1;
    if (fwd) begin
      up = {1'b0, h.pos} + 1'b1;
      n.pos = (up > {1'b0, turn}) ? '0 : up[OUT_POS_W-1:0];
    end else begin
      n.pos = (h.pos == '0) ? turn : h.pos - 1'b1;
    end
    return n;
  endfunction

  function automatic void show(string tag, result_t w);
    $display("  %s: hour %0d minute %0d moved %b/%b on_target %b", tag,
             w.hour_pos, w.minute_pos, w.hour_moved, w.minute_moved, w.on_target);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CLOCKS; k++) begin
        hour_pos_tab[k]    = '0;
        minute_pos_tab[k]  = '0;
        hour_last_tab[k]   = '0;
        minute_last_tab[k] = '0;
        hour_wait_tab[k]   = '0;
        minute_wait_tab[k] = '0;
      end
      gap_cfg  = GAP_RESET;
      turn_cfg = TURN_RESET;
      due_words.delete();
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
      moves_seen   = 0;
      reports      = 0;
    end else begin
      // compare a result word with the oldest prediction
      if (out_valid_o && out_ready_i) begin
        got = {hour_position_o, minute_position_o, hour_moved_o, minute_moved_o,
               on_target_o};
        results_seen++;
        if (got.hour_moved === 1'b1 || got.minute_moved === 1'b1) moves_seen++;
        if (due_words.size() == 0) begin
          fail_count++;
          if (reports < 10) begin
            reports++;
            $display("%0t: result word with nothing expected", $realtime);
            show("actual", got);
          end
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            fail_count++;
            if (reports < 10) begin
              reports++;
              $display("%0t: result word mismatch", $realtime);
              show("expected", want);
              show("actual", got);
            end
          end
        end
      end

      // follow register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:REG_SEL_BIT])
          REG_MIN_GAP:   gap_cfg  = pwdata[GAP_W-1:0];
          REG_FULL_TURN: turn_cfg = pwdata[TURN_W-1:0];
          default: ;
        endcase
      end

      // predict the result of an accepted input word
      if (in_valid_i && in_ready_o) begin
        if (clock_col_i >= GRID_COLS || clock_row_i >= GRID_ROWS) begin
          want = '0;
        end else begin
          slot = clock_col_i * GRID_ROWS + clock_row_i;
          want = '0;
          case (cmd_i)
            CMD_STEP: begin
              hour_h = hand_advance('{pos: hour_pos_tab[slot], last: hour_last_tab[slot],
                                      wait_cnt: hour_wait_tab[slot], moved: 1'b0},
                                    hour_target_i, now_us_i, hour_forward_i,
                                    hour_delay_i, gap_cfg, turn_cfg);
              minute_h = hand_advance('{pos: minute_pos_tab[slot],
                                        last: minute_last_tab[slot],
                                        wait_cnt: minute_wait_tab[slot], moved: 1'b0},
                                      minute_target_i, now_us_i, minute_forward_i,
                                      minute_delay_i, gap_cfg, turn_cfg);
              hour_pos_tab[slot]    = hour_h.pos;
              hour_last_tab[slot]   = hour_h.last;
              hour_wait_tab[slot]   = hour_h.wait_cnt;
              minute_pos_tab[slot]  = minute_h.pos;
              minute_last_tab[slot] = minute_h.last;
              minute_wait_tab[slot] = minute_h.wait_cnt;
              want.hour_moved   = hour_h.moved;
              want.minute_moved = minute_h.moved;
            end
            CMD_ZERO: begin
              hour_pos_tab[slot]   = '0;
              minute_pos_tab[slot] = '0;
            end
            CMD_LOAD: begin
              hour_wait_tab[slot]   = hour_wait_load_i;
              minute_wait_tab[slot] = minute_wait_load_i;
            end
            default: ;
          endcase
          want.hour_pos   = hour_pos_tab[slot];
          want.minute_pos = minute_pos_tab[slot];
          want.on_target  = (hour_pos_tab[slot] == hour_target_i) &&
                            (minute_pos_tab[slot] == minute_target_i);
        end
        due_words.push_back(want);
      end
      pending = due_words.size();
    end
  end

endmodule

// File: tb/tb_clock_hand_step_scheduler_unit.sv
// Testbench top for the clock hand step scheduler: clock, reset, register
// writes and input/result traffic. Depends on chss_pkg, the block and chss_step_checker.
`timescale 1ns / 100ps

module tb_clock_hand_step_scheduler_unit;
  import chss_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 6;
  localparam int PHASE_WORDS  = 275;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [NOW_W-1:0]   now;
    logic [TGT_W-1:0]   ht;
    logic [TGT_W-1:0]   mt;
    logic               hf;
    logic               mf;
    logic [DELAY_W-1:0] hd;
    logic [DELAY_W-1:0] md;
    logic [WAIT_W-1:0]  hw;
    logic [WAIT_W-1:0]  mw;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata, prdata;
  logic in_valid_i, in_ready_o;
  logic [CMD_W-1:0] cmd_i;
  logic [COL_W-1:0] clock_col_i;
  logic [ROW_W-1:0] clock_row_i;
  logic [NOW_W-1:0] now_us_i;
  logic [TGT_W-1:0] hour_target_i, minute_target_i;
  logic hour_forward_i, minute_forward_i;
  logic [DELAY_W-1:0] hour_delay_i, minute_delay_i;
  logic [WAIT_W-1:0] hour_wait_load_i, minute_wait_load_i;
  logic out_valid_o, out_ready_i;
  logic [OUT_POS_W-1:0] hour_position_o, minute_position_o;
  logic hour_moved_o, minute_moved_o, on_target_o;

  int fail_count, pending, results_seen, moves_seen;
  int cycles;
  int step_words, zero_words, load_words, spare_words, off_grid_words;
  int settings_used;
  bit calm;
  int unsigned gap_now, turn_now;
  logic [NOW_W-1:0] t_base;
  int unsigned gap_set [PHASES]  = '{1000, 0, 1000000, 500, 0, 37};
  int unsigned turn_set [PHASES] = '{20, 3, 65535, 0, 65535, 1};

  clock_hand_step_scheduler_unit DUT (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .clock_col_i, .clock_row_i, .now_us_i,
    .hour_target_i, .minute_target_i, .hour_forward_i, .minute_forward_i,
    .hour_delay_i, .minute_delay_i, .hour_wait_load_i, .minute_wait_load_i,
    .out_valid_o, .out_ready_i, .hour_position_o, .minute_position_o,
    .hour_moved_o, .minute_moved_o, .on_target_o
  );

  chss_step_checker step_check (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_ready_o, .cmd_i, .clock_col_i, .clock_row_i, .now_us_i,
    .hour_target_i, .minute_target_i, .hour_forward_i, .minute_forward_i,
    .hour_delay_i, .minute_delay_i, .hour_wait_load_i, .minute_wait_load_i,
    .out_valid_o, .out_ready_i, .hour_position_o, .minute_position_o,
    .hour_moved_o, .minute_moved_o, .on_target_o,
    .fail_count, .pending, .results_seen, .moves_seen
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Idle draw before a word: zero while calm, else zero half the time and nonzero otherwise
  function automatic int idle_draw();
    if (calm) return 0;
    return $urandom_range(0, 1) ? 0 : int'($urandom_range(1, 17));
  endfunction

  function automatic word_t word_of(logic [CMD_W-1:0] cmd, int col, int row,
                                    logic [NOW_W-1:0] now, logic [TGT_W-1:0] ht,
                                    logic [TGT_W-1:0] mt, logic hf, logic mf,
                                    logic [DELAY_W-1:0] hd, logic [DELAY_W-1:0] md,
                                    logic [WAIT_W-1:0] hw, logic [WAIT_W-1:0] mw);
    word_t w;
    w = '{cmd, COL_W'(col), ROW_W'(row), now, ht, mt, hf, mf, hd, md, hw, mw};
    return w;
  endfunction

  // Random word: mostly steps on a handful of busy clocks with a rising time base
  function automatic word_t roll_word();
    word_t       w;
    int unsigned r;
    int unsigned span;
    r = $urandom_range(0, 99);
    w.cmd = (r < 80) ? CMD_STEP : (r < 87) ? CMD_ZERO : (r < 95) ? CMD_LOAD : CMD_SPARE;
    if ($urandom_range(0, 99) < 60) begin
      w.col = COL_W'($urandom_range(0, 1));
      w.row = ROW_W'($urandom_range(0, 1));
    end else begin
      w.col = COL_W'($urandom_range(0, 7));
      w.row = ($urandom_range(0, 19) == 0) ? ROW_W'(3) : ROW_W'($urandom_range(0, 2));
    end
    r = $urandom_range(0, 99);
    if (r < 8) begin
      w.now = $urandom();
    end else if (r < 13) begin
      t_base = t_base - $urandom_range(1, 5000);
      w.now = t_base;
    end else begin
      t_base = t_base + $urandom_range(0, 2 * (gap_now + 900));
      w.now = t_base;
    end
    span = (turn_now >= 65535) ? 65535 : turn_now + 1;
    w.ht = ($urandom_range(0, 9) < 7) ? TGT_W'($urandom_range(0, span)) : TGT_W'($urandom());
    w.mt = ($urandom_range(0, 9) < 7) ? TGT_W'($urandom_range(0, span)) : TGT_W'($urandom());
    w.hf = 1'($urandom_range(0, 1));
    w.mf = 1'($urandom_range(0, 1));
    w.hd = ($urandom_range(0, 4) == 0) ? DELAY_W'($urandom()) : DELAY_W'($urandom_range(0, 8));
    w.md = ($urandom_range(0, 4) == 0) ? DELAY_W'($urandom()) : DELAY_W'($urandom_range(0, 8));
    w.hw = ($urandom_range(0, 9) == 0) ? WAIT_W'($urandom()) : WAIT_W'($urandom_range(0, 3));
    w.mw = ($urandom_range(0, 9) == 0) ? WAIT_W'($urandom()) : WAIT_W'($urandom_range(0, 3));
    return w;
  endfunction

  // Offer one word after its idle gap and hold it until accepted
  task automatic send_word(input word_t w);
    int idle;
    idle = idle_draw();
    if (idle > 0) begin
      in_valid_i = 1'b0;
      repeat (idle) @(negedge clk_i);
    end
    cmd_i              = w.cmd;
    clock_col_i        = w.col;
    clock_row_i        = w.row;
    now_us_i           = w.now;
    hour_target_i      = w.ht;
    minute_target_i    = w.mt;
    hour_forward_i     = w.hf;
    minute_forward_i   = w.mf;
    hour_delay_i       = w.hd;
    minute_delay_i     = w.md;
    hour_wait_load_i   = w.hw;
    minute_wait_load_i = w.mw;
    in_valid_i         = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (w.row == ROW_W'(3)) off_grid_words++;
    case (w.cmd)
      CMD_STEP:  step_words++;
      CMD_ZERO:  zero_words++;
      CMD_LOAD:  load_words++;
      default:   spare_words++;
    endcase
  endtask

  // Hold the sender until every expected result has come back
  task automatic drain_words();
    in_valid_i = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [APB_DATA_W-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_W'(int'(idx) << REG_SEL_BIT);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Every word gives a result, so an empty prediction store means idle
  task automatic set_config(input int unsigned gap, input int unsigned turn);
    drain_words();
    write_reg(REG_MIN_GAP, APB_DATA_W'(gap));
    write_reg(REG_FULL_TURN, APB_DATA_W'(turn));
    gap_now  = gap;
    turn_now = turn;
    settings_used++;
  endtask

  // Result side: stall a drawn number of cycles before each result word
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Cycle limit
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_valid_i = 1'b0; cmd_i = '0; clock_col_i = '0; clock_row_i = '0; now_us_i = '0;
    hour_target_i = '0; minute_target_i = '0; hour_forward_i = 1'b0;
    minute_forward_i = 1'b0; hour_delay_i = '0; minute_delay_i = '0;
    hour_wait_load_i = '0; minute_wait_load_i = '0;
    calm = 1'b0; t_base = '0; gap_now = 32'(GAP_RESET); turn_now = 32'(TURN_RESET);
    step_words = 0; zero_words = 0; load_words = 0; spare_words = 0;
    off_grid_words = 0; settings_used = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: time edges, wait counts, wraps, address and command corners
    set_config(0, 4320);
    send_word(word_of(CMD_STEP, 0, 0, 32'd1, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd1, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd0, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_LOAD, 0, 0, 32'd0, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd2, 16'hFFFF));
    send_word(word_of(CMD_STEP, 0, 0, 32'd10, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd20, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd30, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_LOAD, 0, 0, 32'd30, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_ZERO, 0, 0, 32'd30, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd40, 16'd100, 16'd100, 0, 0, 8'd0, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd41, 16'd100, 16'd100, 0, 0, 8'hFF, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd25541, 16'd100, 16'd100, 0, 0, 8'hFF, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd25542, 16'd100, 16'd100, 0, 0, 8'hFF, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'h8000_63C6, 16'd100, 16'd100, 0, 0, 8'd0, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_ZERO, 0, 0, 32'd0, 16'd0, 16'd0, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 0, 0, 32'd99, 16'd0, 16'd0, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 3, 3, 32'd500, 16'd9, 16'd9, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_SPARE, 0, 0, 32'd600, 16'd0, 16'd0, 1, 1, 8'd0, 8'd0,
                      16'd7, 16'd7));
    send_word(word_of(CMD_STEP, 7, 2, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 1, 8'hFF, 8'hFF,
                      16'hFFFF, 16'hFFFF));
    send_word(word_of(CMD_LOAD, 7, 2, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1, 1, 8'hFF, 8'hFF,
                      16'hFFFF, 16'h0000));
    // a full turn of zero pins every step at zero
    set_config(0, 0);
    send_word(word_of(CMD_STEP, 1, 0, 32'd100, 16'd5, 16'd5, 1, 1, 8'd0, 8'd0, 16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 1, 0, 32'd200, 16'd5, 16'd5, 0, 0, 8'd0, 8'd0, 16'd0, 16'd0));
    set_config(1000000, 65535);
    send_word(word_of(CMD_STEP, 2, 1, 32'd1000001, 16'd9, 16'd9, 0, 0, 8'd0, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 2, 1, 32'd2000001, 16'd9, 16'd9, 1, 1, 8'd0, 8'd0,
                      16'd0, 16'd0));
    send_word(word_of(CMD_STEP, 2, 1, 32'd3000002, 16'd9, 16'd9, 1, 1, 8'd0, 8'd0,
                      16'd0, 16'd0));

    // Random phases, one register setting each, with an unstalled stretch
    t_base = 32'd5000000;
    for (int p = 0; p < PHASES; p++) begin
      set_config(gap_set[p], turn_set[p]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        calm = (i >= 100 && i < 140);
        if ($urandom_range(0, 49) == 0) drain_words();
        send_word(roll_word());
      end
      calm = 1'b0;
    end

    // Let the last results come back, then allow the pipeline to settle
    drain_words();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d words: %0d step, %0d zero, %0d load, %0d spare, %0d off the grid,",
             step_words + zero_words + load_words + spare_words, step_words, zero_words,
             load_words, spare_words, off_grid_words);
    $display("under %0d register settings; %0d results checked, %0d with a hand step.",
             settings_used, results_seen, moves_seen);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
